// File: hdl/eets_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the I2C EEPROM transfer sequencer.
// No dependencies; used by the channel interfaces, the top level and the checker.
package eets_pkg;

   localparam int OP_W     = 3;
   localparam int KIND_W   = 3;
   localparam int FIELD_W  = 16;
   localparam int MADDR_W  = 15;
   localparam int DELAY_W  = 8;
   localparam int NAK_W    = 4;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [NAK_W-1:0]   RETRY_LIMIT_RST = 4'd10;
   localparam logic [DELAY_W-1:0] FIRST_DELAY_RST = 8'd2;
   localparam logic [DELAY_W-1:0] RETRY_DELAY_RST = 8'd1;
   localparam logic [NAK_W-1:0]   NAK_MAX         = 4'hF;

   typedef enum logic [OP_W-1:0] {
      OP_START_READ  = 3'd0,
      OP_START_WRITE = 3'd1,
      OP_POLL_RESULT = 3'd2,
      OP_WRITE_DONE  = 3'd3,
      OP_READ_DONE   = 3'd4
   } op_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_IDLE     = 3'd0,
      KIND_POLL     = 3'd1,
      KIND_WRITE    = 3'd2,
      KIND_READ     = 3'd3,
      KIND_DONE_OK  = 3'd4,
      KIND_DONE_ERR = 3'd5,
      KIND_REJECTED = 3'd6
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RETRY_LIMIT = 2'd0,
      CSR_FIRST_DELAY = 2'd1,
      CSR_RETRY_DELAY = 2'd2
   } csr_index_type;

endpackage

// File: hdl/eets_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the sequencer: event requests in, results out.
// Depends on eets_pkg for field widths.
interface eets_req_if
   import eets_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [OP_W-1:0]      op;
   logic [FIELD_W-1:0]   address;
   logic [FIELD_W-1:0]   length;
   logic                 ack;
   logic [FIELD_W-1:0]   count;

   modport source (output valid, op, address, length, ack, count, input ready);
   modport sink   (input valid, op, address, length, ack, count, output ready);
endinterface

interface eets_rsp_if
   import eets_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [KIND_W-1:0]    kind;
   logic [MADDR_W-1:0]   mem_address;
   logic [FIELD_W-1:0]   xfer_length;
   logic [FIELD_W-1:0]   data_offset;
   logic [DELAY_W-1:0]   delay;
   logic                 last;

   modport source (output valid, kind, mem_address, xfer_length, data_offset, delay, last,
                   input ready);
   modport sink   (input valid, kind, mem_address, xfer_length, data_offset, delay, last,
                   output ready);
endinterface

// File: hdl/i2c_eeprom_transfer_sequencer.sv
`timescale 1ns / 1ps
// Path: a request transfer is captured in the event register, and its result is then
// loaded into the result register, which drives the result channel.
// Throughput: one event per cycle while the sink takes results. A result held by a stalled
// sink blocks the event register, and the request side stalls once that register is full.
// Reset (synchronous, active high): job idle, all counters zero, registers at
// retry_limit 10, first_poll_delay 2, retry_poll_delay 1. MEM_BYTES and PAGE_BYTES
// are powers of two; the address wraps at MEM_BYTES.
module i2c_eeprom_transfer_sequencer
   import eets_pkg::*;
#(
   parameter int PAGE_BYTES = 64,
   parameter int MEM_BYTES  = 32768
) (
   input  logic                  clock,
   input  logic                  reset,
   eets_req_if.sink              req_bus,
   eets_rsp_if.source            rsp_bus,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int ADDR_W = $clog2(MEM_BYTES);
   localparam int PAGE_W = $clog2(PAGE_BYTES);
   localparam int ROOM_W = PAGE_W + 1;

   // Bytes that fit from addr up to the next page edge, capped by what is left.
   function automatic logic [FIELD_W-1:0] chunk_len(input logic [ADDR_W-1:0] addr,
                                                     input logic [FIELD_W-1:0] left);
      logic [ROOM_W-1:0] room;
      room = ROOM_W'(PAGE_BYTES) - ROOM_W'(addr[PAGE_W-1:0]);
      return (left < FIELD_W'(room)) ? left : FIELD_W'(room);
   endfunction

   // ---------------- configuration registers ----------------
   logic [NAK_W-1:0]   retry_limit_ff;
   logic [DELAY_W-1:0] first_delay_ff;
   logic [DELAY_W-1:0] retry_delay_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         retry_limit_ff <= RETRY_LIMIT_RST;
         first_delay_ff <= FIRST_DELAY_RST;
         retry_delay_ff <= RETRY_DELAY_RST;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_RETRY_LIMIT: retry_limit_ff <= csr_wdata[NAK_W-1:0];
            CSR_FIRST_DELAY: first_delay_ff <= csr_wdata;
            CSR_RETRY_DELAY: retry_delay_ff <= csr_wdata;
            default: ;  // writes past the register list are dropped
         endcase
      end
   end

   // ---------------- event register ----------------
   logic                stg_valid_ff, stg_valid_in;
   logic [OP_W-1:0]     stg_op_ff;
   logic [FIELD_W-1:0]  stg_addr_ff;
   logic [FIELD_W-1:0]  stg_len_ff;
   logic                stg_ack_ff;
   logic [FIELD_W-1:0]  stg_cnt_ff;

   logic req_take;
   logic process;
   logic rsp_valid_ff, rsp_valid_in;

   // Retire the staged event when the result register can take its result.
   assign process     = stg_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !stg_valid_ff || process;
   assign req_take    = req_bus.valid && req_bus.ready;

   always_comb begin
      stg_valid_in = stg_valid_ff;
      if (req_take)
         stg_valid_in = 1'b1;
      else if (process)
         stg_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
      end else begin
         stg_valid_ff <= stg_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         stg_op_ff   <= req_bus.op;
         stg_addr_ff <= req_bus.address;
         stg_len_ff  <= req_bus.length;
         stg_ack_ff  <= req_bus.ack;
         stg_cnt_ff  <= req_bus.count;
      end
   end

   // ---------------- job state ----------------
   logic               busy_ff, busy_in;
   logic               dev_ready_ff, dev_ready_in;   // set by an acknowledged poll, cleared by a NAK or an issued write
   logic [ADDR_W-1:0]  cur_addr_ff, cur_addr_in;
   logic [FIELD_W-1:0] write_left_ff, write_left_in;
   logic [FIELD_W-1:0] read_left_ff, read_left_in;
   logic [FIELD_W-1:0] bytes_done_ff, bytes_done_in;
   logic [NAK_W-1:0]   nak_count_ff, nak_count_in;

   // Result of the staged event
   logic               emit;
   kind_type           res_kind;
   logic [MADDR_W-1:0] res_addr;
   logic [FIELD_W-1:0] res_len;
   logic [FIELD_W-1:0] res_off;
   logic [DELAY_W-1:0] res_delay;

   logic               do_advance;
   logic               do_poll;
   logic [DELAY_W-1:0] poll_delay;
   logic               do_finish;
   logic               finish_ok;
   logic [FIELD_W-1:0] moved;
   logic [FIELD_W-1:0] limit;
   logic [FIELD_W:0]   addr_sum;

   always_comb begin
      busy_in       = busy_ff;
      dev_ready_in  = dev_ready_ff;
      cur_addr_in   = cur_addr_ff;
      write_left_in = write_left_ff;
      read_left_in  = read_left_ff;
      bytes_done_in = bytes_done_ff;
      nak_count_in  = nak_count_ff;

      emit       = 1'b0;
      res_kind   = KIND_IDLE;
      res_addr   = '0;
      res_len    = '0;
      res_off    = '0;
      res_delay  = '0;
      do_advance = 1'b0;
      do_poll    = 1'b0;
      poll_delay = '0;
      do_finish  = 1'b0;
      finish_ok  = 1'b0;
      moved      = '0;
      limit      = '0;
      addr_sum   = '0;

      case (op_type'(stg_op_ff))
         OP_START_READ, OP_START_WRITE: begin
            if (busy_ff || ({1'b0, stg_addr_ff} >= (FIELD_W+1)'(MEM_BYTES))) begin
               emit     = 1'b1;
               res_kind = KIND_REJECTED;
            end else begin
               busy_in       = 1'b1;
               cur_addr_in   = stg_addr_ff[ADDR_W-1:0];
               nak_count_in  = '0;
               bytes_done_in = '0;
               write_left_in = (op_type'(stg_op_ff) == OP_START_WRITE) ? stg_len_ff : '0;
               read_left_in  = (op_type'(stg_op_ff) == OP_START_READ)  ? stg_len_ff : '0;
               do_advance    = 1'b1;
            end
         end
         OP_POLL_RESULT: begin
            if (busy_ff) begin
               if (stg_ack_ff) begin
                  dev_ready_in = 1'b1;
                  nak_count_in = '0;
                  do_advance   = 1'b1;
               end else begin
                  dev_ready_in = 1'b0;
                  if (nak_count_ff != NAK_MAX)
                     nak_count_in = nak_count_ff + NAK_W'(1);
                  if (nak_count_in < retry_limit_ff) begin
                     do_poll    = 1'b1;
                     poll_delay = retry_delay_ff;
                  end else begin
                     do_finish = 1'b1;
                  end
               end
            end
         end
         OP_WRITE_DONE, OP_READ_DONE: begin
            if (op_type'(stg_op_ff) == OP_WRITE_DONE)
               limit = chunk_len(cur_addr_ff, write_left_ff);
            else
               limit = read_left_ff;
            if (busy_ff && (limit != '0)) begin
               // Clip the moved count to what this transfer could carry.
               moved = (stg_cnt_ff > limit) ? limit : stg_cnt_ff;
               if (op_type'(stg_op_ff) == OP_WRITE_DONE)
                  write_left_in = write_left_ff - moved;
               else
                  read_left_in = read_left_ff - moved;
               bytes_done_in = bytes_done_ff + moved;
               addr_sum      = (FIELD_W+1)'(cur_addr_ff) + (FIELD_W+1)'(moved);
               cur_addr_in   = addr_sum[ADDR_W-1:0];
               if (((op_type'(stg_op_ff) == OP_WRITE_DONE) && (write_left_in == '0)) ||
                   ((op_type'(stg_op_ff) == OP_READ_DONE) && (read_left_in == '0))) begin
                  do_finish = 1'b1;
                  finish_ok = stg_ack_ff;
               end else if (stg_ack_ff) begin
                  do_advance = 1'b1;
               end else begin
                  // Transfer NAK: count it and re-poll without checking the limit.
                  dev_ready_in = 1'b0;
                  if (nak_count_ff != NAK_MAX)
                     nak_count_in = nak_count_ff + NAK_W'(1);
                  do_poll    = 1'b1;
                  poll_delay = retry_delay_ff;
               end
            end
         end
         default: ;  // stray event codes are dropped
      endcase

      // Issue the next transfer, poll first when the device has not acknowledged,
      // or close the job when nothing is left.
      if (do_advance) begin
         if (write_left_in != '0) begin
            if (dev_ready_in) begin
               dev_ready_in = 1'b0;
               emit     = 1'b1;
               res_kind = KIND_WRITE;
               res_addr = MADDR_W'(cur_addr_in);
               res_len  = chunk_len(cur_addr_in, write_left_in);
               res_off  = bytes_done_in;
            end else begin
               do_poll    = 1'b1;
               poll_delay = first_delay_ff;
            end
         end else if (read_left_in != '0) begin
            if (dev_ready_in) begin
               emit     = 1'b1;
               res_kind = KIND_READ;
               res_addr = MADDR_W'(cur_addr_in);
               res_len  = read_left_in;
               res_off  = bytes_done_in;
            end else begin
               do_poll    = 1'b1;
               poll_delay = first_delay_ff;
            end
         end else begin
            do_finish = 1'b1;
            finish_ok = 1'b1;
         end
      end

      if (do_poll) begin
         emit      = 1'b1;
         res_kind  = KIND_POLL;
         res_addr  = MADDR_W'(cur_addr_in);
         res_delay = poll_delay;
      end

      if (do_finish) begin
         busy_in       = 1'b0;
         write_left_in = '0;
         read_left_in  = '0;
         emit          = 1'b1;
         res_kind      = finish_ok ? KIND_DONE_OK : KIND_DONE_ERR;
         res_off       = bytes_done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         dev_ready_ff  <= 1'b0;
         cur_addr_ff   <= '0;
         write_left_ff <= '0;
         read_left_ff  <= '0;
         bytes_done_ff <= '0;
         nak_count_ff  <= '0;
      end else if (process) begin
         busy_ff       <= busy_in;
         dev_ready_ff  <= dev_ready_in;
         cur_addr_ff   <= cur_addr_in;
         write_left_ff <= write_left_in;
         read_left_ff  <= read_left_in;
         bytes_done_ff <= bytes_done_in;
         nak_count_ff  <= nak_count_in;
      end
   end

   // ---------------- result register ----------------
   logic [KIND_W-1:0]  rsp_kind_ff;
   logic [MADDR_W-1:0] rsp_addr_ff;
   logic [FIELD_W-1:0] rsp_len_ff;
   logic [FIELD_W-1:0] rsp_off_ff;
   logic [DELAY_W-1:0] rsp_delay_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (process && emit)
         rsp_valid_in = 1'b1;
      else if (rsp_bus.ready)
         rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the payload until a new result is loaded.
   always_ff @(posedge clock) begin
      if (process && emit) begin
         rsp_kind_ff  <= res_kind;
         rsp_addr_ff  <= res_addr;
         rsp_len_ff   <= res_len;
         rsp_off_ff   <= res_off;
         rsp_delay_ff <= res_delay;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.kind        = rsp_kind_ff;
   assign rsp_bus.mem_address = rsp_addr_ff;
   assign rsp_bus.xfer_length = rsp_len_ff;
   assign rsp_bus.data_offset = rsp_off_ff;
   assign rsp_bus.delay       = rsp_delay_ff;
   assign rsp_bus.last        = 1'b1;  // every event yields at most one result

endmodule

// File: hdl/eets_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the sequencer result channel, bound to the top level.
// Depends on eets_pkg for result codes and widths.
module eets_checker
   import eets_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [KIND_W-1:0]   rsp_kind,
   input logic [FIELD_W-1:0]  rsp_xfer_length,
   input logic [DELAY_W-1:0]  rsp_delay,
   input logic                rsp_last
);

   // Hold a stalled result.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_kind) && $stable(rsp_xfer_length))
      else $error("result payload changed while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_kind != KIND_IDLE && rsp_kind <= KIND_REJECTED && rsp_last)
      else $error("bad result kind or last flag");

   // Completion and rejection results carry no transfer length and no delay.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_DONE_OK || rsp_kind == KIND_DONE_ERR ||
                    rsp_kind == KIND_REJECTED)
      |-> rsp_xfer_length == '0 && rsp_delay == '0)
      else $error("status result with transfer fields set");

   // Only poll requests carry a delay.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_delay != '0 |-> rsp_kind == KIND_POLL)
      else $error("delay on a non-poll result");

endmodule

bind i2c_eeprom_transfer_sequencer eets_checker u_eets_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_kind        (rsp_bus.kind),
   .rsp_xfer_length (rsp_bus.xfer_length),
   .rsp_delay       (rsp_bus.delay),
   .rsp_last        (rsp_bus.last)
);
